// File: rtl/tkslp_pkg.sv
// Shared types for the two-key short/long press classifier.
`default_nettype none

package tkslp_pkg;

    // Width of the long-press threshold register.
    localparam int unsigned THRESH_BITS = 32;
    // Width of the tick field on the input port.
    localparam int unsigned NOW_BITS    = 32;

    // One result item.
    typedef struct packed {
        logic left_press;
        logic right_press;
        logic circle_press;
        logic home_pulse;
    } t_result;

    // Per-key event flags handed from a key tracker to the top level.
    typedef struct packed {
        logic short_pulse;
        logic long_pulse;
    } t_key_evt;

endpackage

`default_nettype wire

// File: rtl/two_key_short_long_press_classifier.sv
// Top level of the two-key short/long press classifier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | i_in_valid/o_in_stall | key one, key two, launcher flag, now tick
//  out     | output    | o_out_valid/i_out_stall | left, right, circle, home
//  cfg     | input     | i_cfg_we              | long-press threshold (0 = level mode)
//
// One item per cycle sustained while the output is not stalled; an item passes through the
// input register and then the result register. The classification runs in one pass between
// the two registers; outside level mode, key state updates as an item moves into the result register.
// Synchronous active-low reset clears the key state, the threshold and both valids.
// An output stall holds the result register; the input register still takes an item
// while the result register waits, then stalls the input side until it drains.
`default_nettype none

module two_key_short_long_press_classifier #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tkslp_pkg::THRESH_BITS-1:0] i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_key_one_level,
    input  wire logic                             i_key_two_level,
    input  wire logic                             i_launcher_running,
    input  wire logic [tkslp_pkg::NOW_BITS-1:0]   i_now_tick,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_left_press,
    output logic                                  o_right_press,
    output logic                                  o_circle_press,
    output logic                                  o_home_pulse
);
    import tkslp_pkg::*;

    logic [THRESH_BITS-1:0] r_thresh;

    logic                   r_in_vld;
    logic                   r_k1;
    logic                   r_k2;
    logic                   r_launch;
    logic [NOW_BITS-1:0]    r_now;

    logic                   r_out_vld;
    t_result                r_res;
    t_result                n_res;

    logic                   out_free;
    logic                   s1_move;
    logic                   in_take;
    logic                   level_mode;
    logic                   key_adv;
    logic [TICK_BITS-1:0]   now_ticks;
    t_key_evt               evt_one;
    t_key_evt               evt_two;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign level_mode = (r_thresh == '0);
    assign key_adv    = s1_move && !level_mode;
    assign now_ticks  = TICK_BITS'(r_now);

    tkslp_key #(.TICK_BITS(TICK_BITS)) u_key_one (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (key_adv),
        .i_level     (r_k1),
        .i_long_en   (1'b1),
        .i_long_fire (!r_launch),
        .i_now       (now_ticks),
        .i_thresh    (r_thresh),
        .o_evt       (evt_one)
    );

    tkslp_key #(.TICK_BITS(TICK_BITS)) u_key_two (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (key_adv),
        .i_level     (r_k2),
        .i_long_en   (r_launch),
        .i_long_fire (1'b1),
        .i_now       (now_ticks),
        .i_thresh    (r_thresh),
        .o_evt       (evt_two)
    );

    always_comb begin
        if (level_mode) begin
            n_res.left_press   = r_k1;
            n_res.right_press  = r_k2;
            n_res.circle_press = 1'b0;
            n_res.home_pulse   = 1'b0;
        end else begin
            n_res.left_press   = evt_one.short_pulse;
            n_res.right_press  = evt_two.short_pulse;
            n_res.circle_press = evt_two.long_pulse;
            n_res.home_pulse   = evt_one.long_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_k1     <= i_key_one_level;
            r_k2     <= i_key_two_level;
            r_launch <= i_launcher_running;
            r_now    <= i_now_tick;
        end
        if (s1_move) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_left_press   = r_res.left_press;
    assign o_right_press  = r_res.right_press;
    assign o_circle_press = r_res.circle_press;
    assign o_home_pulse   = r_res.home_pulse;

endmodule

`default_nettype wire

// File: rtl/tkslp_key.sv
// Press tracker for one key: press tick capture, long-hold check, release.
`default_nettype none

module tkslp_key #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_adv,
    input  wire logic                            i_level,
    input  wire logic                            i_long_en,
    input  wire logic                            i_long_fire,
    input  wire logic [TICK_BITS-1:0]            i_now,
    input  wire logic [tkslp_pkg::THRESH_BITS-1:0] i_thresh,
    output tkslp_pkg::t_key_evt                  o_evt
);
    import tkslp_pkg::*;

    localparam int unsigned CMP_BITS = (TICK_BITS > THRESH_BITS) ? TICK_BITS : THRESH_BITS;

    logic                 r_held;
    logic                 n_held;
    logic                 r_done;
    logic                 n_done;
    logic [TICK_BITS-1:0] r_tick;
    logic [TICK_BITS-1:0] n_tick;
    logic [TICK_BITS-1:0] elapsed;
    logic                 reached;

    // Held time wraps modulo 2^TICK_BITS.
    assign elapsed = i_now - r_tick;
    assign reached = CMP_BITS'(elapsed) >= CMP_BITS'(i_thresh);

    always_comb begin
        n_held = r_held;
        n_done = r_done;
        n_tick = r_tick;
        o_evt  = '0;
        priority if (i_level && !r_held) begin
            n_held = 1'b1;
            n_done = 1'b0;
            n_tick = i_now;
        end else if (i_level && !r_done && i_long_en && reached) begin
            n_done           = 1'b1;
            o_evt.long_pulse = i_long_fire;
        end else if (!i_level && r_held) begin
            o_evt.short_pulse = !r_done;
            n_held            = 1'b0;
            n_done            = 1'b0;
        end else begin
            // no press, long action or release: hold the state
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_done <= 1'b0;
        end else if (i_adv) begin
            r_held <= n_held;
            r_done <= n_done;
        end
    end

    // Tick is only read while held, and every press writes it.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tick <= n_tick;
        end
    end

endmodule

`default_nettype wire

// File: verif/two_key_short_long_press_classifier_test.sv
// Self-checking testbench for the two-key short/long press classifier.
`timescale 1ns / 1ps

module two_key_short_long_press_classifier_test;

    import tkslp_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n            = 1'b0;
    logic                   i_cfg_we           = 1'b0;
    logic [THRESH_BITS-1:0] i_cfg_wdata        = '0;
    logic                   i_in_valid         = 1'b0;
    logic                   o_in_stall;
    logic                   i_key_one_level    = 1'b0;
    logic                   i_key_two_level    = 1'b0;
    logic                   i_launcher_running = 1'b0;
    logic [NOW_BITS-1:0]    i_now_tick         = '0;
    logic                   o_out_valid;
    logic                   i_out_stall        = 1'b0;
    logic                   o_left_press;
    logic                   o_right_press;
    logic                   o_circle_press;
    logic                   o_home_pulse;

    two_key_short_long_press_classifier dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_key_one_level    (i_key_one_level),
        .i_key_two_level    (i_key_two_level),
        .i_launcher_running (i_launcher_running),
        .i_now_tick         (i_now_tick),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_left_press       (o_left_press),
        .o_right_press      (o_right_press),
        .o_circle_press     (o_circle_press),
        .o_home_pulse       (o_home_pulse)
    );

    // Press tracking state and threshold as the block should hold them.
    logic [THRESH_BITS-1:0] hold_thresh = '0;
    logic                   k1_held     = 1'b0;
    logic                   k1_long     = 1'b0;
    logic [NOW_BITS-1:0]    k1_tick     = '0;
    logic                   k2_held     = 1'b0;
    logic                   k2_long     = 1'b0;
    logic [NOW_BITS-1:0]    k2_tick     = '0;

    t_result expected_presses[$];
    t_result want_res;
    t_result got_res;
    int      err_count   = 0;
    bit      no_idle     = 1'b0;
    int      stall_left  = 0;

    assign got_res = {o_left_press, o_right_press, o_circle_press, o_home_pulse};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Classify one frame and advance the per-key state.
    function automatic t_result classify_frame(input logic k1, input logic k2,
                                               input logic launch,
                                               input logic [NOW_BITS-1:0] now);
        t_result r;
        r = '0;
        if (hold_thresh == 0) begin
            r.left_press  = k1;
            r.right_press = k2;
        end else begin
            if (k1 && !k1_held) begin
                k1_held = 1'b1;
                k1_long = 1'b0;
                k1_tick = now;
            end else if (k1 && !k1_long && NOW_BITS'(now - k1_tick) >= hold_thresh) begin
                k1_long      = 1'b1;
                r.home_pulse = !launch;
            end else if (!k1 && k1_held) begin
                r.left_press = !k1_long;
                k1_held      = 1'b0;
                k1_long      = 1'b0;
                k1_tick      = '0;
            end

            if (k2 && !k2_held) begin
                k2_held = 1'b1;
                k2_long = 1'b0;
                k2_tick = now;
            end else if (k2 && !k2_long && launch &&
                         NOW_BITS'(now - k2_tick) >= hold_thresh) begin
                k2_long        = 1'b1;
                r.circle_press = 1'b1;
            end else if (!k2 && k2_held) begin
                r.right_press = !k2_long;
                k2_held       = 1'b0;
                k2_long       = 1'b0;
                k2_tick       = '0;
            end
        end
        return r;
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t ERROR: %s expected %0b actual %0b", $time, name, want, got);
            err_count++;
        end
    endtask

    // Input side: predict every accepted frame.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_presses.push_back(classify_frame(i_key_one_level, i_key_two_level,
                                                      i_launcher_running, i_now_tick));
    end

    // Output side: random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= idle_len();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_presses.size() == 0) begin
                $display("%0t ERROR: result %b arrived with none expected", $time, got_res);
                err_count++;
            end else begin
                want_res = expected_presses.pop_front();
                check_field("left_press",   want_res.left_press,   o_left_press);
                check_field("right_press",  want_res.right_press,  o_right_press);
                check_field("circle_press", want_res.circle_press, o_circle_press);
                check_field("home_pulse",   want_res.home_pulse,   o_home_pulse);
            end
        end
    end

    task automatic send_frame(input logic k1, input logic k2, input logic launch,
                              input logic [NOW_BITS-1:0] now);
        int gap;
        i_in_valid         <= 1'b1;
        i_key_one_level    <= k1;
        i_key_two_level    <= k2;
        i_launcher_running <= launch;
        i_now_tick         <= now;
        do @(posedge i_clk); while (o_in_stall);
        gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every frame in flight has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_presses.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THRESH_BITS-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        hold_thresh = value;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_level_mode();
        set_threshold('0);
        send_frame(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        send_frame(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_frame(1'b0, 1'b1, 1'b1, 32'h0000_0000);
        send_frame(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_short_release();
        set_threshold(32'd100);
        send_frame(1'b1, 1'b0, 1'b0, 32'd10);
        send_frame(1'b1, 1'b1, 1'b0, 32'd20);
        send_frame(1'b0, 1'b1, 1'b0, 32'd30);
        send_frame(1'b0, 1'b0, 1'b1, 32'd40);
    endtask

    task automatic test_long_hold();
        set_threshold(32'd100);
        // press both just before the tick wraps, cross the threshold after it
        send_frame(1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
        send_frame(1'b1, 1'b1, 1'b1, 32'h0000_0053);
        send_frame(1'b1, 1'b1, 1'b0, 32'h0000_0054);
        send_frame(1'b1, 1'b1, 1'b1, 32'h0000_0060);
        send_frame(1'b0, 1'b0, 1'b0, 32'h0000_0061);
        // key one long while the launcher runs: latched, no home, no left
        send_frame(1'b1, 1'b0, 1'b1, 32'd0);
        send_frame(1'b1, 1'b0, 1'b1, 32'd200);
        send_frame(1'b0, 1'b0, 1'b0, 32'd201);
        // key two long with the launcher idle: release still gives right
        send_frame(1'b0, 1'b1, 1'b0, 32'd0);
        send_frame(1'b0, 1'b1, 1'b0, 32'd500);
        send_frame(1'b0, 1'b0, 1'b0, 32'd501);
    endtask

    task automatic test_threshold_extremes();
        set_threshold(32'hFFFF_FFFF);
        send_frame(1'b1, 1'b1, 1'b1, 32'd5);
        send_frame(1'b1, 1'b1, 1'b1, 32'd3);
        send_frame(1'b1, 1'b1, 1'b1, 32'd4);
        send_frame(1'b0, 1'b0, 1'b0, 32'd4);
        set_threshold(32'd1);
        send_frame(1'b1, 1'b0, 1'b0, 32'd7);
        send_frame(1'b1, 1'b0, 1'b0, 32'd7);
        send_frame(1'b1, 1'b0, 1'b0, 32'd8);
        send_frame(1'b0, 1'b0, 1'b0, 32'd9);
    endtask

    // Level mode in the middle of a press must leave the press state alone.
    task automatic test_mode_switch();
        set_threshold(32'd1);
        send_frame(1'b1, 1'b1, 1'b0, 32'd50);
        set_threshold('0);
        send_frame(1'b0, 1'b1, 1'b0, 32'd60);
        set_threshold(32'd1);
        send_frame(1'b1, 1'b1, 1'b1, 32'd70);
        send_frame(1'b0, 1'b0, 1'b0, 32'd71);
    endtask

    task automatic test_random_frames(input int per_phase);
        int                     ph;
        int                     i;
        int                     pick;
        int                     step_max;
        logic                   k1;
        logic                   k2;
        logic                   launch;
        logic [NOW_BITS-1:0]    tick;
        logic [THRESH_BITS-1:0] thr;
        k1     = 1'b0;
        k2     = 1'b0;
        launch = 1'b0;
        tick   = $urandom;
        for (ph = 0; ph < 6; ph++) begin
            step_max = 3;
            case (ph)
                0: thr = '0;
                1: thr = 32'd1;
                2: thr = $urandom_range(2, 12);
                3: thr = 32'hFFFF_FFFF;
                4: thr = $urandom;
                default: begin
                    thr      = $urandom_range(13, 60);
                    step_max = 20;
                end
            endcase
            set_threshold(thr);
            no_idle = (ph == 2);
            for (i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise frame
                    k1     = 1'($urandom);
                    k2     = 1'($urandom);
                    launch = 1'($urandom);
                    tick   = $urandom;
                end else begin
                    // hold keys for runs of frames, advance the tick slowly
                    if ($urandom_range(0, 4) == 0)  k1 = !k1;
                    if ($urandom_range(0, 4) == 0)  k2 = !k2;
                    if ($urandom_range(0, 11) == 0) launch = !launch;
                    pick = $urandom_range(0, 39);
                    if (pick == 0)
                        tick = $urandom;
                    else if (pick == 1)
                        tick = k1_tick - 1'b1;
                    else if (pick == 2)
                        tick = k2_tick - 1'b1;
                    else
                        tick = tick + NOW_BITS'($urandom_range(0, step_max));
                end
                send_frame(k1, k2, launch, tick);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_level_mode();
        test_short_release();
        test_long_hold();
        test_threshold_extremes();
        test_mode_switch();
        test_random_frames(150);

        wait_drained();
        if (expected_presses.size() != 0) begin
            $display("%0t ERROR: %0d results never arrived", $time, expected_presses.size());
            err_count++;
        end
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: two_key_short_long_press_classifier.f
rtl/tkslp_pkg.sv
rtl/tkslp_key.sv
rtl/two_key_short_long_press_classifier.sv
verif/two_key_short_long_press_classifier_test.sv
